// ===== src/cda_pkg.sv =====
// Shared types, constants and calendar helper functions for the date arithmetic block.
package cda_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned SER_W  = 22;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned CNT_W  = 16;

  localparam int unsigned MAX_YEAR   = 9999;
  // Last serial: one before 1 January of the year after MAX_YEAR
  localparam int unsigned SERIAL_MAX = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                       + MAX_YEAR / 400 - 1;
  // floor(p / 100) == (p * RECIP100) >> 19, exact for p below 43699
  localparam int unsigned RECIP100   = 5243;
  // Years per day in 2^-32 units, for the first year estimate
  localparam int unsigned YEAR_RECIP = 11759222;
  // Inverse of 25 modulo 2^14: divisible by 25 iff product lands at or below the limit
  localparam int unsigned INV25      = 7209;
  localparam int unsigned DIV25_LIM  = (2 ** YEAR_W - 1) / 25;

  localparam logic [1:0]       CMD_ADD   = 2'd0;
  localparam logic [1:0]       CMD_SUB   = 2'd1;
  localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_MAIN, OP_SER_MAIN, OP_MUL_OTHER, OP_SER_OTHER,
    OP_STEP, OP_EST, OP_MUL_EST, OP_START, OP_YFIX, OP_MON, OP_OUT
  } op_e;

  typedef struct packed {
    logic valid;
    logic is_step;
    logic yfix_done;
    logic mon_done;
  } stat_t;

  function automatic logic leap_f(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] t;
    logic              div25;
    t     = YEAR_W'(y * YEAR_W'(INV25));
    div25 = (t <= YEAR_W'(DIV25_LIM));
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] dim_f(input logic [MON_W-1:0] m,
                                              input logic [YEAR_W-1:0] y);
    logic [DAY_W-1:0] r;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:    r = leap_f(y) ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [8:0] cum_f(input logic [MON_W-1:0] m,
                                       input logic [YEAR_W-1:0] y);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    if (m > MONTH_FEB && leap_f(y)) r = r + 9'd1;
    return r;
  endfunction

  function automatic logic date_ok_f(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                     input logic [YEAR_W-1:0] y);
    return (y != '0) && (y <= YEAR_W'(MAX_YEAR)) && (m >= MONTH_JAN) && (m <= MONTH_DEC)
           && (d != '0) && (d <= dim_f(m, y));
  endfunction

endpackage

// ===== src/cda_datapath.sv =====
// Datapath: operand registers, year-start unit, year search and month walk.
module cda_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cda_pkg::op_e        op_i,
  input  logic [63:0]         in_data_i,
  output cda_pkg::stat_t      stat_o,
  output logic [47:0]         out_data_o
);
  import cda_pkg::*;

  logic [1:0]        cmd_q;
  logic [DAY_W-1:0]  d_q, od_q;
  logic [MON_W-1:0]  m_q, om_q;
  logic [YEAR_W-1:0] y_q, oy_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [YEAR_W-1:0] p_q;
  logic [22:0]       m365_q;
  logic [26:0]       m100_q;
  logic [SER_W-1:0]  sa_q, sb_q, s_q, st_q;
  logic              hit_q;
  logic [YEAR_W-1:0] q_q, yr_q;
  logic [MON_W-1:0]  mon_q;
  logic [8:0]        r_q;
  logic [47:0]       out_q;

  logic [YEAR_W-1:0] p_sel;
  logic [SER_W-1:0]  start_w, diff_w, dist_w;
  logic [45:0]       est_w;
  logic [8:0]        ylen_back, ylen_fwd;
  logic [DAY_W-1:0]  mlen;
  logic              back_w, fwd_w, valid_w, step_w;

  // Status towards the controller
  assign step_w    = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);
  assign valid_w   = date_ok_f(d_q, m_q, y_q) && (step_w || date_ok_f(od_q, om_q, oy_q));
  assign start_w   = SER_W'(m365_q + 23'(p_q >> 2) - 23'(m100_q >> 19) + 23'(m100_q >> 21));
  assign est_w     = 46'(s_q) * 46'(YEAR_RECIP);
  assign diff_w    = s_q - st_q;
  assign ylen_back = 9'd365 + 9'(leap_f(q_q));
  assign ylen_fwd  = 9'd365 + 9'(leap_f(q_q + 14'd1));
  assign back_w    = st_q > s_q;
  assign fwd_w     = !back_w && (diff_w >= SER_W'(ylen_fwd));
  assign mlen      = dim_f(mon_q, yr_q);
  assign dist_w    = (sa_q > sb_q) ? sa_q - sb_q : sb_q - sa_q;

  assign stat_o.valid     = valid_w;
  assign stat_o.is_step   = step_w;
  assign stat_o.yfix_done = !back_w && !fwd_w;
  assign stat_o.mon_done  = (r_q < 9'(mlen)) || (mon_q == MONTH_DEC);

  // Year operand for the year-start unit
  always_comb begin
    case (op_i)
      OP_MUL_MAIN:  p_sel = y_q - 14'd1;
      OP_MUL_OTHER: p_sel = oy_q - 14'd1;
      default:      p_sel = q_q;
    endcase
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        cmd_q <= in_data_i[1:0];
        d_q   <= in_data_i[6:2];
        m_q   <= in_data_i[10:7];
        y_q   <= in_data_i[24:11];
        cnt_q <= in_data_i[40:25];
        od_q  <= in_data_i[45:41];
        om_q  <= in_data_i[49:46];
        oy_q  <= in_data_i[63:50];
        hit_q <= 1'b0;
      end
      OP_MUL_MAIN, OP_MUL_OTHER, OP_MUL_EST: begin
        p_q    <= p_sel;
        m365_q <= 23'(p_sel) * 23'd365;
        m100_q <= 27'(p_sel) * 27'(RECIP100);
      end
      OP_SER_MAIN:  sa_q <= start_w + SER_W'(cum_f(m_q, y_q)) + SER_W'(d_q) - 22'd1;
      OP_SER_OTHER: sb_q <= start_w + SER_W'(cum_f(om_q, oy_q)) + SER_W'(od_q) - 22'd1;
      OP_STEP: begin
        if (cmd_q == CMD_ADD) begin
          if (SER_W'(cnt_q) > SER_W'(SERIAL_MAX) - sa_q) begin
            s_q   <= SER_W'(SERIAL_MAX);
            hit_q <= 1'b1;
          end else begin
            s_q <= sa_q + SER_W'(cnt_q);
          end
        end else begin
          if (SER_W'(cnt_q) > sa_q) begin
            s_q   <= '0;
            hit_q <= 1'b1;
          end else begin
            s_q <= sa_q - SER_W'(cnt_q);
          end
        end
      end
      OP_EST:   q_q  <= est_w[45:32];
      OP_START: st_q <= start_w;
      OP_YFIX: begin
        if (back_w) begin
          q_q  <= q_q - 14'd1;
          st_q <= st_q - SER_W'(ylen_back);
        end else if (fwd_w) begin
          q_q  <= q_q + 14'd1;
          st_q <= st_q + SER_W'(ylen_fwd);
        end else begin
          r_q   <= diff_w[8:0];
          mon_q <= MONTH_JAN;
          yr_q  <= q_q + 14'd1;
        end
      end
      OP_MON: begin
        r_q   <= r_q - 9'(mlen);
        mon_q <= mon_q + 4'd1;
      end
      default: ;
    endcase
  end

  // Result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (op_i == OP_OUT) begin
      if (!valid_w)     out_q <= '0;
      else if (step_w)  out_q <= {1'b0, hit_q, 1'b1, 22'd0, yr_q, mon_q, DAY_W'(r_q + 9'd1)};
      else              out_q <= {1'b0, 1'b0, 1'b1, dist_w, 14'd0, 4'd0, 5'd0};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/cda_ctrl.sv =====
// Controller: sequences one item through the datapath and owns the stream handshakes.
module cda_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cda_pkg::stat_t stat_i,
  output cda_pkg::op_e   op_o
);
  import cda_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_MA, ST_MB, ST_OA, ST_OB, ST_STEP, ST_EST,
    ST_YA, ST_YB, ST_YFIX, ST_MON, ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   ovld_q, ovld_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovld_q;

  // Next state and datapath command
  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q && !out_ready_i;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        op_o    = OP_LOAD;
        state_d = ST_CHECK;
      end
      ST_CHECK: state_d = stat_i.valid ? ST_MA : ST_FIN;
      ST_MA: begin
        op_o    = OP_MUL_MAIN;
        state_d = ST_MB;
      end
      ST_MB: begin
        op_o    = OP_SER_MAIN;
        state_d = stat_i.is_step ? ST_STEP : ST_OA;
      end
      ST_OA: begin
        op_o    = OP_MUL_OTHER;
        state_d = ST_OB;
      end
      ST_OB: begin
        op_o    = OP_SER_OTHER;
        state_d = ST_FIN;
      end
      ST_STEP: begin
        op_o    = OP_STEP;
        state_d = ST_EST;
      end
      ST_EST: begin
        op_o    = OP_EST;
        state_d = ST_YA;
      end
      ST_YA: begin
        op_o    = OP_MUL_EST;
        state_d = ST_YB;
      end
      ST_YB: begin
        op_o    = OP_START;
        state_d = ST_YFIX;
      end
      ST_YFIX: begin
        op_o = OP_YFIX;
        if (stat_i.yfix_done) state_d = ST_MON;
      end
      ST_MON: begin
        if (stat_i.mon_done) state_d = ST_FIN;
        else                 op_o    = OP_MON;
      end
      ST_FIN: if (!ovld_q || out_ready_i) begin
        op_o    = OP_OUT;
        ovld_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

// ===== src/calendar_date_arithmetic.sv =====
// Top level: Gregorian date add, subtract and distance, one result word per input word.
// An invalid date goes straight to the output; a distance converts both dates to serials;
//   a step converts the date, applies the count, then runs the year search and month walk.
// One word is processed at a time; the next input word is taken once the result
//   is registered, while that result may still wait at the output.
// Reset: asynchronous, active low; clears the controller and the output register.
module calendar_date_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd, day, month, year, count, other_day, other_month, other_year
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_day, out_month, out_year, distance, date_valid, range_hit, zero pad
  output logic [47:0] m_axis_tdata_o
);
  import cda_pkg::*;

  op_e   op;
  stat_t stat;

  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  cda_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .in_data_i  (s_axis_tdata_i),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ===== src/cda_checker.sv =====
// Port-level checks for the date arithmetic block, bound to the top level.
module cda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  // A stalled result word stays presented
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word dropped or changed while stalled");

  // Invalid input gives an all-zero word
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[45] |-> m_axis_tdata_o == 48'd0)
    else $error("invalid date with non-zero result");

  // Saturation only on a valid step, never with a distance
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[46] |->
      m_axis_tdata_o[45] && m_axis_tdata_o[44:23] == 22'd0)
    else $error("range flag on a non-step result");

  // A step result carries a sane month and day
  a_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[8:5] != 4'd0 |->
      m_axis_tdata_o[8:5] <= 4'd12 && m_axis_tdata_o[4:0] != 5'd0)
    else $error("step result with impossible month or day");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
